[hw/rtl/xrng_pkg.sv]
// Shared types and constants for the xoshiro256++ random generator.
`default_nettype none

package xrng_pkg;

    localparam int unsigned WORD_W    = 64;
    localparam int unsigned UNIFORM_W = 54;
    localparam int unsigned NUM_WORDS = 4;
    localparam int unsigned IDX_W     = 2;

    localparam logic [WORD_W-1:0] GOLDEN_STEP = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [WORD_W-1:0] MIX_MUL_A   = 64'hBF58_476D_1CE4_E5B9;
    localparam logic [WORD_W-1:0] MIX_MUL_B   = 64'h94D0_49BB_1331_11EB;

    localparam int unsigned ROT_OUT   = 23;
    localparam int unsigned ROT_STATE = 45;
    localparam int unsigned SHL_STATE = 17;
    localparam int unsigned MIX_SHR_A = 30;
    localparam int unsigned MIX_SHR_B = 27;
    localparam int unsigned MIX_SHR_C = 31;
    localparam int unsigned UNIFORM_SHR = 11;

    typedef enum logic {
        OP_DRAW   = 1'b0,
        OP_RESEED = 1'b1
    } opcode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MIX_A_MUL,
        ST_MIX_A_SUM,
        ST_MIX_B_MUL,
        ST_MIX_B_SUM
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic             draw;
        logic             seed_load;
        logic             pp_capture;
        logic             pp_use_b;
        logic             sum_capture;
        logic             word_store;
        logic [IDX_W-1:0] word_idx;
    } xrng_cmd_t;

    function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] v,
                                               input int unsigned amount);
        return (v << amount) | (v >> (WORD_W - amount));
    endfunction

endpackage

`default_nettype wire

[hw/rtl/xoshiro256pp_random_generator.sv]
// Top level of the xoshiro256++ random generator with splitmix64 reseeding.
//
// Requests arrive on the s_ stream: s_tuser carries the opcode (draw or
// reseed) and s_tdata the 64-bit seed, which only a reseed uses. Each draw
// request gives one result on the m_ stream; a reseed gives none.
// A draw is taken in the idle state and its result sits in the output
// register on the next cycle, and draws can be taken every cycle while
// the receiver keeps m_tready high. A new draw is
// taken while a result waits only if that result leaves in the same cycle.
// A reseed produces four splitmix64 outputs, each needing two
// passes through the shared 32-bit partial-product multipliers, and each
// pass is followed by a sum state; s_tready stays low meanwhile.
// When the receiver stalls, the result holds and s_tready drops.
// Reset clears all four state words to zero, so draws before the first
// reseed return zero, and empties the output register.
`default_nettype none

module xoshiro256pp_random_generator (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [63:0]   s_tdata,   // [63:0] seed_value
    input  wire logic [0:0]    s_tuser,   // [0] opcode
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [119:0]       m_tdata    // [63:0] raw_value, [117:64] uniform_fixed
);

    xrng_pkg::xrng_cmd_t cmd;
    logic [xrng_pkg::WORD_W-1:0]    raw_value;
    logic [xrng_pkg::UNIFORM_W-1:0] uniform_fixed;

    xrng_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .opcode   (s_tuser[0]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    xrng_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .seed_value    (s_tdata),
        .raw_value     (raw_value),
        .uniform_fixed (uniform_fixed)
    );

    assign m_tdata = {2'b00, uniform_fixed, raw_value};

endmodule

`default_nettype wire

[hw/rtl/xrng_ctrl.sv]
// Controller state machine: request handshakes, reseed sequencing and output valid.
`default_nettype none

module xrng_ctrl (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_tvalid,
    output logic                 s_tready,
    input  wire logic            opcode,
    output logic                 m_tvalid,
    input  wire logic            m_tready,
    output xrng_pkg::xrng_cmd_t  cmd
);

    xrng_pkg::state_t state_reg, state_next;
    logic [xrng_pkg::IDX_W-1:0] idx_reg, idx_next;
    logic out_valid_reg, out_valid_next;
    logic accept;
    logic is_draw;

    assign s_tready = (state_reg == xrng_pkg::ST_IDLE) && (!out_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign is_draw  = (opcode == xrng_pkg::OP_DRAW);
    assign m_tvalid = out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= xrng_pkg::ST_IDLE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state.
    always_comb begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            xrng_pkg::ST_IDLE: begin
                if (accept) begin
                    if (is_draw) begin
                        out_valid_next = 1'b1;
                    end else begin
                        idx_next   = '0;
                        state_next = xrng_pkg::ST_MIX_A_MUL;
                    end
                end
            end
            xrng_pkg::ST_MIX_A_MUL: state_next = xrng_pkg::ST_MIX_A_SUM;
            xrng_pkg::ST_MIX_A_SUM: state_next = xrng_pkg::ST_MIX_B_MUL;
            xrng_pkg::ST_MIX_B_MUL: state_next = xrng_pkg::ST_MIX_B_SUM;
            xrng_pkg::ST_MIX_B_SUM: begin
                idx_next = idx_reg + 1'b1;
                if (idx_reg == xrng_pkg::IDX_W'(xrng_pkg::NUM_WORDS - 1)) begin
                    state_next = xrng_pkg::ST_IDLE;
                end else begin
                    state_next = xrng_pkg::ST_MIX_A_MUL;
                end
            end
            default: state_next = xrng_pkg::ST_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        cmd          = '0;
        cmd.word_idx = idx_reg;
        case (state_reg)
            xrng_pkg::ST_IDLE: begin
                cmd.draw      = accept && is_draw;
                cmd.seed_load = accept && !is_draw;
            end
            xrng_pkg::ST_MIX_A_MUL: cmd.pp_capture = 1'b1;
            xrng_pkg::ST_MIX_A_SUM: cmd.sum_capture = 1'b1;
            xrng_pkg::ST_MIX_B_MUL: begin
                cmd.pp_capture = 1'b1;
                cmd.pp_use_b   = 1'b1;
            end
            xrng_pkg::ST_MIX_B_SUM: cmd.word_store = 1'b1;
            default: cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

[hw/rtl/xrng_datapath.sv]
// Datapath: state words, xoshiro256++ step, splitmix64 mixer and output register.
`default_nettype none

module xrng_datapath (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire xrng_pkg::xrng_cmd_t             cmd,
    input  wire logic [xrng_pkg::WORD_W-1:0]     seed_value,
    output logic [xrng_pkg::WORD_W-1:0]          raw_value,
    output logic [xrng_pkg::UNIFORM_W-1:0]       uniform_fixed
);

    localparam int unsigned W  = xrng_pkg::WORD_W;
    localparam int unsigned HW = W / 2;

    logic [W-1:0] words_reg [xrng_pkg::NUM_WORDS];
    logic [W-1:0] counter_reg;
    logic [W-1:0] prod_reg;
    logic [W-1:0] pp_low_reg;
    logic [HW-1:0] pp_cross_reg;
    logic [W-1:0] raw_reg;

    logic [W-1:0] step_out;
    logic [W-1:0] shifted, n0, n1, n2, n3;
    logic [W-1:0] mul_in, mul_k;
    logic [W-1:0] pp_low;
    logic [HW-1:0] pp_cross;
    logic [W-1:0] prod_sum;

    // One xoshiro256++ step on the current words.
    always_comb begin
        step_out = xrng_pkg::rotl(words_reg[0] + words_reg[3], xrng_pkg::ROT_OUT)
                   + words_reg[0];
        shifted  = words_reg[1] << xrng_pkg::SHL_STATE;
        n2 = words_reg[2] ^ words_reg[0];
        n3 = words_reg[3] ^ words_reg[1];
        n1 = words_reg[1] ^ n2;
        n0 = words_reg[0] ^ n3;
    end

    // The 64-bit product modulo 2^64 is split into a full low-half product and
    // the low halves of the two cross products, summed in the following cycle.
    always_comb begin
        if (cmd.pp_use_b) begin
            mul_in = prod_reg ^ (prod_reg >> xrng_pkg::MIX_SHR_B);
            mul_k  = xrng_pkg::MIX_MUL_B;
        end else begin
            mul_in = counter_reg ^ (counter_reg >> xrng_pkg::MIX_SHR_A);
            mul_k  = xrng_pkg::MIX_MUL_A;
        end
        pp_low   = mul_in[HW-1:0] * mul_k[HW-1:0];
        pp_cross = mul_in[W-1:HW] * mul_k[HW-1:0] + mul_in[HW-1:0] * mul_k[W-1:HW];
        prod_sum = pp_low_reg + {pp_cross_reg, {HW{1'b0}}};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < int'(xrng_pkg::NUM_WORDS); i++) begin
                words_reg[i] <= '0;
            end
        end else if (cmd.draw) begin
            words_reg[0] <= n0;
            words_reg[1] <= n1;
            words_reg[2] <= n2 ^ shifted;
            words_reg[3] <= xrng_pkg::rotl(n3, xrng_pkg::ROT_STATE);
        end else if (cmd.word_store) begin
            words_reg[cmd.word_idx] <= prod_sum ^ (prod_sum >> xrng_pkg::MIX_SHR_C);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.draw) begin
            raw_reg <= step_out;
        end
        if (cmd.seed_load) begin
            counter_reg <= seed_value + xrng_pkg::GOLDEN_STEP;
        end else if (cmd.word_store) begin
            counter_reg <= counter_reg + xrng_pkg::GOLDEN_STEP;
        end
        if (cmd.pp_capture) begin
            pp_low_reg   <= pp_low;
            pp_cross_reg <= pp_cross;
        end
        if (cmd.sum_capture) begin
            prod_reg <= prod_sum;
        end
    end

    assign raw_value     = raw_reg;
    assign uniform_fixed = {raw_reg[W-1:xrng_pkg::UNIFORM_SHR], 1'b1};

endmodule

`default_nettype wire

[sim/tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the xoshiro256++ generator: directed table, then random requests.
`default_nettype none

module tb;

    localparam int CLK_HALF        = 6;
    localparam int RESET_CYCLES    = 7;
    localparam int RANDOM_REQUESTS = 1700;
    localparam int PHASE_LEN       = 200;
    localparam int STALL_LIMIT     = 2000;
    localparam int DRAIN_CYCLES    = 40;
    localparam int MAX_PRINTS      = 40;
    localparam int NUM_ROWS        = 20;

    localparam logic [xrng_pkg::WORD_W-1:0] ALL_ONES = {xrng_pkg::WORD_W{1'b1}};
    localparam logic [xrng_pkg::WORD_W-1:0] TOP_BIT  =
        {1'b1, {(xrng_pkg::WORD_W-1){1'b0}}};

    typedef struct packed {
        logic [xrng_pkg::WORD_W-1:0]    raw;
        logic [xrng_pkg::UNIFORM_W-1:0] uniform;
    } draw_t;

    typedef struct {
        xrng_pkg::opcode_t              op;
        logic [xrng_pkg::WORD_W-1:0]    seed;
        bit                             literal_exp;
        logic [xrng_pkg::WORD_W-1:0]    raw;
        logic [xrng_pkg::UNIFORM_W-1:0] uniform;
    } stim_row_t;

    logic         aclk = 1'b0;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [63:0]  s_tdata;    // [63:0] seed_value
    logic [0:0]   s_tuser;    // [0] opcode
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [119:0] m_tdata;    // [63:0] raw_value, [117:64] uniform_fixed

    logic [xrng_pkg::WORD_W-1:0] gen_words [xrng_pkg::NUM_WORDS];
    draw_t             expected_draws [$];
    int                mismatches = 0;
    int                quiet_cycles = 0;
    int                send_idle_pct = 0;
    int                recv_stall_pct = 0;

    // Draws ahead of the first reseed must come out as zero with the smallest uniform value.
    stim_row_t directed_rows [NUM_ROWS] = '{
        '{xrng_pkg::OP_DRAW,   ALL_ONES,                1'b1, 64'd0, 54'd1},
        '{xrng_pkg::OP_DRAW,   64'd0,                   1'b1, 64'd0, 54'd1},
        '{xrng_pkg::OP_DRAW,   TOP_BIT,                 1'b1, 64'd0, 54'd1},
        '{xrng_pkg::OP_RESEED, 64'd0,                   1'b0, 64'd0, 54'd0},
        '{xrng_pkg::OP_DRAW,   64'd0,                   1'b0, 64'd0, 54'd0},
        '{xrng_pkg::OP_DRAW,   ALL_ONES,                1'b0, 64'd0, 54'd0},
        '{xrng_pkg::OP_RESEED, ALL_ONES,                1'b0, 64'd0, 54'd0},
        '{xrng_pkg::OP_DRAW,   ALL_ONES,                1'b0, 64'd0, 54'd0},
        '{xrng_pkg::OP_DRAW,   64'd0,                   1'b0, 64'd0, 54'd0},
        '{xrng_pkg::OP_RESEED, TOP_BIT,                 1'b0, 64'd0, 54'd0},
        '{xrng_pkg::OP_DRAW,   64'd0,                   1'b0, 64'd0, 54'd0},
        '{xrng_pkg::OP_RESEED, 64'd1,                   1'b0, 64'd0, 54'd0},
        '{xrng_pkg::OP_DRAW,   64'd0,                   1'b0, 64'd0, 54'd0},
        '{xrng_pkg::OP_DRAW,   64'd0,                   1'b0, 64'd0, 54'd0},
        '{xrng_pkg::OP_RESEED, 64'h5555_5555_5555_5555, 1'b0, 64'd0, 54'd0},
        '{xrng_pkg::OP_RESEED, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 64'd0, 54'd0},
        '{xrng_pkg::OP_DRAW,   64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 64'd0, 54'd0},
        '{xrng_pkg::OP_DRAW,   64'h5555_5555_5555_5555, 1'b0, 64'd0, 54'd0},
        '{xrng_pkg::OP_RESEED, ~TOP_BIT,                1'b0, 64'd0, 54'd0},
        '{xrng_pkg::OP_DRAW,   64'd0,                   1'b0, 64'd0, 54'd0}
    };

    xoshiro256pp_random_generator dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #CLK_HALF aclk = ~aclk;

    function automatic logic [xrng_pkg::WORD_W-1:0] rotate_left(
            input logic [xrng_pkg::WORD_W-1:0] v, input int unsigned amount);
        return (v << amount) | (v >> (xrng_pkg::WORD_W - amount));
    endfunction

    // One splitmix64 output for a counter value that has already been stepped.
    function automatic logic [xrng_pkg::WORD_W-1:0] splitmix_out(
            input logic [xrng_pkg::WORD_W-1:0] counter);
        logic [xrng_pkg::WORD_W-1:0] z;
        z = counter;
        z = (z ^ (z >> xrng_pkg::MIX_SHR_A)) * xrng_pkg::MIX_MUL_A;
        z = (z ^ (z >> xrng_pkg::MIX_SHR_B)) * xrng_pkg::MIX_MUL_B;
        return z ^ (z >> xrng_pkg::MIX_SHR_C);
    endfunction

    task automatic reseed_words(input logic [xrng_pkg::WORD_W-1:0] seed);
        logic [xrng_pkg::WORD_W-1:0] counter;
        counter = seed;
        for (int i = 0; i < xrng_pkg::NUM_WORDS; i++) begin
            counter = counter + xrng_pkg::GOLDEN_STEP;
            gen_words[i] = splitmix_out(counter);
        end
    endtask

    task automatic advance_words(output draw_t d);
        logic [xrng_pkg::WORD_W-1:0] shifted;
        d.raw     = rotate_left(gen_words[0] + gen_words[3], xrng_pkg::ROT_OUT)
                    + gen_words[0];
        d.uniform = {d.raw[xrng_pkg::WORD_W-1:xrng_pkg::UNIFORM_SHR], 1'b1};
        shifted   = gen_words[1] << xrng_pkg::SHL_STATE;
        gen_words[2] = gen_words[2] ^ gen_words[0];
        gen_words[3] = gen_words[3] ^ gen_words[1];
        gen_words[1] = gen_words[1] ^ gen_words[2];
        gen_words[0] = gen_words[0] ^ gen_words[3];
        gen_words[2] = gen_words[2] ^ shifted;
        gen_words[3] = rotate_left(gen_words[3], xrng_pkg::ROT_STATE);
    endtask

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_PRINTS)
            $display("%0t ns: %s", $time, msg);
    endtask

    task automatic set_phase(input int p);
        case (p % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
            default: begin send_idle_pct = 13; recv_stall_pct = 13; end
        endcase
    endtask

    // Drives one request and waits for its acceptance. The table may override the
    // predicted result of a draw, but the generator words still advance on a draw.
    task automatic send_request(input xrng_pkg::opcode_t op,
                                input logic [xrng_pkg::WORD_W-1:0] seed,
                                input bit literal_exp, input draw_t literal);
        draw_t d;
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= seed;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        if (op == xrng_pkg::OP_RESEED) begin
            reseed_words(seed);
        end else begin
            advance_words(d);
            expected_draws.push_back(literal_exp ? literal : d);
        end
    endtask

    function automatic logic [xrng_pkg::WORD_W-1:0] random_seed();
        case ($urandom_range(15))
            0: return 64'd0;
            1: return ALL_ONES;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    always @(posedge aclk) begin
        draw_t exp_d;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_draws.size() == 0) begin
                report_mismatch($sformatf("unexpected result raw=%h", m_tdata[63:0]));
            end else begin
                exp_d = expected_draws.pop_front();
                if (m_tdata[63:0] !== exp_d.raw)
                    report_mismatch($sformatf("raw_value got %h expected %h",
                                              m_tdata[63:0], exp_d.raw));
                if (m_tdata[117:64] !== exp_d.uniform)
                    report_mismatch($sformatf("uniform_fixed got %h expected %h",
                                              m_tdata[117:64], exp_d.uniform));
            end
        end
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("xoshiro256pp_random_generator: mismatch");
            $finish;
        end
    end

    initial begin
        draw_t             lit;
        xrng_pkg::opcode_t op;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tuser  <= xrng_pkg::OP_DRAW;
        s_tdata  <= 64'd0;
        for (int i = 0; i < xrng_pkg::NUM_WORDS; i++)
            gen_words[i] = '0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        set_phase(3);
        foreach (directed_rows[i]) begin
            lit.raw     = directed_rows[i].raw;
            lit.uniform = directed_rows[i].uniform;
            send_request(directed_rows[i].op, directed_rows[i].seed,
                         directed_rows[i].literal_exp, lit);
        end

        // Mostly draws with a reseed now and then, so long runs of each state get drawn.
        lit = '0;
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            if (n % PHASE_LEN == 0)
                set_phase(n / PHASE_LEN);
            op = ($urandom_range(15) == 0) ? xrng_pkg::OP_RESEED : xrng_pkg::OP_DRAW;
            send_request(op, random_seed(), 1'b0, lit);
        end
        s_tvalid <= 1'b0;

        while (expected_draws.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("xoshiro256pp_random_generator: match");
        end else begin
            $display("xoshiro256pp_random_generator: mismatch");
        end
        $finish;
    end

endmodule

`default_nettype wire

[files.f]
hw/rtl/xrng_pkg.sv
hw/rtl/xrng_ctrl.sv
hw/rtl/xrng_datapath.sv
hw/rtl/xoshiro256pp_random_generator.sv
sim/tb.sv
